// File: rtl/ray_triangle_hit_barycentric_defines.svh
// ----------------------------------------------------------------------------
// Ray/triangle hit test - assertion macros
// Shared property wrappers for the RTL checks.
// ----------------------------------------------------------------------------
`ifndef RAY_TRIANGLE_HIT_BARYCENTRIC_DEFINES_SVH
`define RAY_TRIANGLE_HIT_BARYCENTRIC_DEFINES_SVH

// same-cycle implication
`define RTB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ray/triangle check failed");

// next-cycle implication
`define RTB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ray/triangle check failed");

`endif

// File: rtl/rtb_pkg.sv
// ----------------------------------------------------------------------------
// rtb_pkg
// Types, widths and helper functions of the ray/triangle hit test.
// ----------------------------------------------------------------------------
package rtb_pkg;

   localparam int COORD_W    = 16;
   localparam int VEC_W      = 3 * COORD_W;
   localparam int EDGE_W     = COORD_W + 1;
   localparam int CROSS_W    = 2 * EDGE_W + 1;
   localparam int SCAL_W     = 52;
   localparam int DIV_W      = SCAL_W - 1;
   localparam int DIST_W     = 32;
   localparam int DIST_FRAC  = 16;
   localparam int QUO_W      = DIST_W;
   localparam int DIV_STAGES = QUO_W;
   localparam int BARY_W     = 17;
   localparam int PNT_W      = COORD_W + DIST_W + 1;
   localparam int SUM_W      = COORD_W + DIST_W - DIST_FRAC + 2;

   localparam logic [BARY_W-1:0] BARY_ONE = BARY_W'(1 << DIST_FRAC);

   // test modes
   localparam logic OP_FULL    = 1'b0;
   localparam logic OP_OCCLUDE = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [VEC_W-1:0]  vert_a;
      logic [VEC_W-1:0]  vert_b;
      logic [VEC_W-1:0]  vert_c;
      logic [VEC_W-1:0]  ray_origin;
      logic [VEC_W-1:0]  ray_dir;
      logic [DIST_W-1:0] dist_min;
      logic [DIST_W-1:0] dist_max;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] hit_distance;
      logic [BARY_W-1:0] bary_u;
      logic [BARY_W-1:0] bary_v;
      logic [BARY_W-1:0] bary_w;
      logic [VEC_W-1:0]  hit_point;
   } rsp_type;

   // per-item data that rides along with the arithmetic
   typedef struct packed {
      logic              opcode;
      logic              miss;
      logic              sat;
      logic [DIST_W-1:0] dist_min;
      logic [DIST_W-1:0] dist_max;
      logic [VEC_W-1:0]  ray_origin;
      logic [VEC_W-1:0]  ray_dir;
   } side_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] shq;
   } div_lane_type;

   function automatic logic signed [COORD_W-1:0] vec_comp(input logic [VEC_W-1:0] vec,
                                                           input logic [1:0] idx);
      return $signed(vec[idx*COORD_W +: COORD_W]);
   endfunction

   // start of num * 2^DIST_FRAC / den: high bits seed the remainder
   function automatic div_lane_type div_init(input logic [DIV_W-1:0] num);
      div_lane_type res;
      res.rem = num >> DIST_FRAC;
      res.shq = {num[DIST_FRAC-1:0], {(QUO_W-DIST_FRAC){1'b0}}};
      return res;
   endfunction

   // one restoring step: dividend bits leave the top, quotient bits enter below
   function automatic div_lane_type div_step(input div_lane_type lane,
                                             input logic [DIV_W-1:0] den);
      div_lane_type     res;
      logic [DIV_W-1:0] trial;
      trial   = {lane.rem[DIV_W-2:0], lane.shq[QUO_W-1]};
      res.shq = {lane.shq[QUO_W-2:0], 1'b0};
      res.rem = trial;
      if (trial >= den) begin
         res.rem    = trial - den;
         res.shq[0] = 1'b1;
      end
      return res;
   endfunction

endpackage

// File: rtl/ray_triangle_hit_barycentric.sv
// ----------------------------------------------------------------------------
// ray_triangle_hit_barycentric
// Single-sided ray/triangle hit test with barycentric weights.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one test per transfer: opcode, three vertices, ray origin
//   and direction (packed signed Q8.8) and a Q16.16 distance window.
//   rsp_* returns exactly one result per test, in order: hit flag, Q16.16
//   distance, Q1.16 weights and the clamped hit point; a miss is all zero.
//   From request to response there are 5 geometry stages, 32 divider
//   stages (one quotient bit each) and 2 output stages.
//   Throughput is one test per cycle while rsp_ready is high; the bit-serial
//   divider pipeline sets the depth, the 17x35 products set the per-stage logic.
//   When rsp_ready is low, the result holds in the output register and the
//   stages behind it keep filling empty slots; req_ready drops only once
//   every stage holds an item.
//   Reset clears all valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
module ray_triangle_hit_barycentric import rtb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic             fr_valid, fr_ready, dv_valid, dv_ready;
   logic [DIV_W-1:0] num_t, num_v, num_w, den;
   logic [QUO_W-1:0] q_t, q_v, q_w;
   side_type         fr_side, dv_side;

   rtb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .num_t     (num_t),
      .num_v     (num_v),
      .num_w     (num_w),
      .den       (den),
      .out_side  (fr_side)
   );

   rtb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .num_t     (num_t),
      .num_v     (num_v),
      .num_w     (num_w),
      .den       (den),
      .in_side   (fr_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .q_t       (q_t),
      .q_v       (q_v),
      .q_w       (q_w),
      .out_side  (dv_side)
   );

   rtb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .q_t       (q_t),
      .q_v       (q_v),
      .q_w       (q_w),
      .in_side   (dv_side),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/rtb_front.sv
// ----------------------------------------------------------------------------
// rtb_front
// Geometry pipeline: edges, cross products, dot products and early rejects.
// ----------------------------------------------------------------------------
module rtb_front import rtb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  req_type          in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [DIV_W-1:0] num_t,
   output logic [DIV_W-1:0] num_v,
   output logic [DIV_W-1:0] num_w,
   output logic [DIV_W-1:0] den,
   output side_type         out_side
);

   logic [4:0] vld_ff;
   logic [4:0] en;
   side_type   side_ff [5];

   logic signed [EDGE_W-1:0]  e1_in [3], e2_in [3], ao_in [3], nd_in [3];
   logic signed [EDGE_W-1:0]  e1_ff [3], e2_ff [3], ao_ff [3], nd_ff [3];
   logic signed [EDGE_W-1:0]  e1_s2_ff [3], e2_s2_ff [3], ao_s2_ff [3];
   logic signed [CROSS_W-1:0] n_in [3], bc_in [3], n_ff [3], bc_ff [3];
   logic signed [SCAL_W-1:0]  pd_in [3], pt_in [3], pv_in [3], pw_in [3];
   logic signed [SCAL_W-1:0]  pd_ff [3], pt_ff [3], pv_ff [3], pw_ff [3];
   logic signed [SCAL_W-1:0]  d_in, t_in, v_in, w_in, d_ff, t_ff, v_ff, w_ff;
   logic signed [SCAL_W:0]    vw_sum;
   logic                      miss_in, sat_in;
   logic [DIV_W-1:0]          num_t_ff, num_v_ff, num_w_ff, den_ff;
   side_type                  side0, side5_in;

   always_comb begin
      en[4]    = !vld_ff[4] || out_ready;
      en[3]    = !vld_ff[3] || en[4];
      en[2]    = !vld_ff[2] || en[3];
      en[1]    = !vld_ff[1] || en[2];
      en[0]    = !vld_ff[0] || en[1];
      in_ready = en[0];
   end

   // stage 1: edges, origin offset and negated direction
   always_comb begin
      side0            = '0;
      side0.opcode     = in_data.opcode;
      side0.dist_min   = in_data.dist_min;
      side0.dist_max   = in_data.dist_max;
      side0.ray_origin = in_data.ray_origin;
      side0.ray_dir    = in_data.ray_dir;
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = EDGE_W'(vec_comp(in_data.vert_b, 2'(i)))
                  - EDGE_W'(vec_comp(in_data.vert_a, 2'(i)));
         e2_in[i] = EDGE_W'(vec_comp(in_data.vert_c, 2'(i)))
                  - EDGE_W'(vec_comp(in_data.vert_a, 2'(i)));
         ao_in[i] = EDGE_W'(vec_comp(in_data.ray_origin, 2'(i)))
                  - EDGE_W'(vec_comp(in_data.vert_a, 2'(i)));
         nd_in[i] = -EDGE_W'(vec_comp(in_data.ray_dir, 2'(i)));
      end
   end

   // stage 2: normal and the barycentric cross product
   always_comb begin
      n_in[0]  = e1_ff[1] * e2_ff[2] - e1_ff[2] * e2_ff[1];
      n_in[1]  = e1_ff[2] * e2_ff[0] - e1_ff[0] * e2_ff[2];
      n_in[2]  = e1_ff[0] * e2_ff[1] - e1_ff[1] * e2_ff[0];
      bc_in[0] = nd_ff[1] * ao_ff[2] - nd_ff[2] * ao_ff[1];
      bc_in[1] = nd_ff[2] * ao_ff[0] - nd_ff[0] * ao_ff[2];
      bc_in[2] = nd_ff[0] * ao_ff[1] - nd_ff[1] * ao_ff[0];
   end

   // stage 3: products of the dot products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pd_in[i] = vec_comp(side_ff[1].ray_dir, 2'(i)) * n_ff[i];
         pt_in[i] = ao_s2_ff[i] * n_ff[i];
         pv_in[i] = e2_s2_ff[i] * bc_ff[i];
         pw_in[i] = e1_s2_ff[i] * bc_ff[i];
      end
   end

   // stage 4: sums
   always_comb begin
      d_in = -(pd_ff[0] + pd_ff[1] + pd_ff[2]);
      t_in = pt_ff[0] + pt_ff[1] + pt_ff[2];
      v_in = pv_ff[0] + pv_ff[1] + pv_ff[2];
      w_in = -(pw_ff[0] + pw_ff[1] + pw_ff[2]);
   end

   // stage 5: back face, behind origin, barycentric bounds and distance saturation
   always_comb begin
      vw_sum  = (SCAL_W+1)'(v_ff) + (SCAL_W+1)'(w_ff);
      miss_in = (d_ff <= 0) || t_ff[SCAL_W-1] || v_ff[SCAL_W-1] || w_ff[SCAL_W-1]
             || (v_ff > d_ff) || (vw_sum > (SCAL_W+1)'(d_ff));
      sat_in  = (t_ff >>> DIST_FRAC) >= d_ff;
      side5_in      = side_ff[3];
      side5_in.miss = miss_in;
      side5_in.sat  = sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         if (en[1]) vld_ff[1] <= vld_ff[0];
         if (en[2]) vld_ff[2] <= vld_ff[1];
         if (en[3]) vld_ff[3] <= vld_ff[2];
         if (en[4]) vld_ff[4] <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= side0;
         e1_ff      <= e1_in;
         e2_ff      <= e2_in;
         ao_ff      <= ao_in;
         nd_ff      <= nd_in;
      end
      if (en[1]) begin
         side_ff[1] <= side_ff[0];
         n_ff       <= n_in;
         bc_ff      <= bc_in;
         e1_s2_ff   <= e1_ff;
         e2_s2_ff   <= e2_ff;
         ao_s2_ff   <= ao_ff;
      end
      if (en[2]) begin
         side_ff[2] <= side_ff[1];
         pd_ff      <= pd_in;
         pt_ff      <= pt_in;
         pv_ff      <= pv_in;
         pw_ff      <= pw_in;
      end
      if (en[3]) begin
         side_ff[3] <= side_ff[2];
         d_ff       <= d_in;
         t_ff       <= t_in;
         v_ff       <= v_in;
         w_ff       <= w_in;
      end
      if (en[4]) begin
         side_ff[4] <= side5_in;
         num_t_ff   <= t_ff[DIV_W-1:0];
         num_v_ff   <= v_ff[DIV_W-1:0];
         num_w_ff   <= w_ff[DIV_W-1:0];
         den_ff     <= d_ff[DIV_W-1:0];
      end
   end

   assign out_valid = vld_ff[4];
   assign out_side  = side_ff[4];
   assign num_t     = num_t_ff;
   assign num_v     = num_v_ff;
   assign num_w     = num_w_ff;
   assign den       = den_ff;

endmodule

// File: rtl/rtb_div.sv
// ----------------------------------------------------------------------------
// rtb_div
// Pipelined restoring divider, one quotient bit per stage, three lanes
// (distance, v, w) sharing one denominator.
// ----------------------------------------------------------------------------
module rtb_div import rtb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [DIV_W-1:0] num_t,
   input  logic [DIV_W-1:0] num_v,
   input  logic [DIV_W-1:0] num_w,
   input  logic [DIV_W-1:0] den,
   input  side_type         in_side,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [QUO_W-1:0] q_t,
   output logic [QUO_W-1:0] q_v,
   output logic [QUO_W-1:0] q_w,
   output side_type         out_side
);

   logic             vld_ff  [DIV_STAGES];
   logic             en      [DIV_STAGES];
   div_lane_type     lane_ff [DIV_STAGES][3];
   logic [DIV_W-1:0] den_ff  [DIV_STAGES];
   side_type         side_ff [DIV_STAGES];

   logic             src_vld  [DIV_STAGES];
   div_lane_type     src_lane [DIV_STAGES][3];
   logic [DIV_W-1:0] src_den  [DIV_STAGES];
   side_type         src_side [DIV_STAGES];
   div_lane_type     nxt_lane [DIV_STAGES][3];

   always_comb begin
      en[DIV_STAGES-1] = !vld_ff[DIV_STAGES-1] || out_ready;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   always_comb begin
      src_vld[0]     = in_valid;
      src_den[0]     = den;
      src_side[0]    = in_side;
      src_lane[0][0] = div_init(num_t);
      src_lane[0][1] = div_init(num_v);
      src_lane[0][2] = div_init(num_w);
      for (int k = 1; k < DIV_STAGES; k++) begin
         src_vld[k]  = vld_ff[k-1];
         src_den[k]  = den_ff[k-1];
         src_side[k] = side_ff[k-1];
         src_lane[k] = lane_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         for (int l = 0; l < 3; l++) begin
            nxt_lane[k][l] = div_step(src_lane[k][l], src_den[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en[k]) begin
            vld_ff[k] <= src_vld[k];
         end
         if (en[k]) begin
            lane_ff[k] <= nxt_lane[k];
            den_ff[k]  <= src_den[k];
            side_ff[k] <= src_side[k];
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];
   assign q_t       = lane_ff[DIV_STAGES-1][0].shq;
   assign q_v       = lane_ff[DIV_STAGES-1][1].shq;
   assign q_w       = lane_ff[DIV_STAGES-1][2].shq;

endmodule

// File: rtl/rtb_back.sv
// ----------------------------------------------------------------------------
// rtb_back
// Distance window, weights, hit point and the result register.
// ----------------------------------------------------------------------------
`include "ray_triangle_hit_barycentric_defines.svh"

module rtb_back import rtb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [QUO_W-1:0] q_t,
   input  logic [QUO_W-1:0] q_v,
   input  logic [QUO_W-1:0] q_w,
   input  side_type         in_side,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   logic                     en_p1, en_out;
   logic                     vld_p1_ff, rsp_valid_ff;
   logic [DIST_W-1:0]        dist_sat;
   logic                     win_ok, hit_in;
   logic [BARY_W-1:0]        bu_in;
   logic signed [PNT_W-1:0]  pp_in [3];

   logic                     hit_ff;
   logic [DIST_W-1:0]        dist_ff;
   logic [BARY_W-1:0]        bu_ff, bv_ff, bw_ff;
   logic signed [PNT_W-1:0]  pp_ff [3];
   logic [VEC_W-1:0]         org_ff;

   logic signed [SUM_W-1:0]  psum [3];
   logic [VEC_W-1:0]         point;
   rsp_type                  rsp_in, rsp_data_ff;
   logic [BARY_W:0]          bary_total;

   assign en_out   = !rsp_valid_ff || rsp_ready;
   assign en_p1    = !vld_p1_ff || en_out;
   assign in_ready = en_p1;

   always_comb begin
      dist_sat = in_side.sat ? '1 : q_t;
      win_ok   = (in_side.opcode == OP_OCCLUDE)
               ? (dist_sat != '0)
               : (dist_sat >= in_side.dist_min && dist_sat <= in_side.dist_max);
      hit_in   = !in_side.miss && win_ok;
      bu_in    = BARY_ONE - q_v[BARY_W-1:0] - q_w[BARY_W-1:0];
      for (int i = 0; i < 3; i++) begin
         pp_in[i] = vec_comp(in_side.ray_dir, 2'(i)) * $signed({1'b0, dist_sat});
      end
   end

   // floor shift, add origin, clamp to the coordinate range
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         psum[i] = SUM_W'(pp_ff[i] >>> DIST_FRAC) + SUM_W'(vec_comp(org_ff, 2'(i)));
         if (psum[i][SUM_W-1:COORD_W-1] == '0 || psum[i][SUM_W-1:COORD_W-1] == '1) begin
            point[i*COORD_W +: COORD_W] = psum[i][COORD_W-1:0];
         end else begin
            point[i*COORD_W +: COORD_W] = {psum[i][SUM_W-1], {(COORD_W-1){!psum[i][SUM_W-1]}}};
         end
      end
      rsp_in = '0;
      if (hit_ff) begin
         rsp_in.hit          = 1'b1;
         rsp_in.hit_distance = dist_ff;
         rsp_in.bary_u       = bu_ff;
         rsp_in.bary_v       = bv_ff;
         rsp_in.bary_w       = bw_ff;
         rsp_in.hit_point    = point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p1_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_p1) vld_p1_ff <= in_valid;
         if (en_out) rsp_valid_ff <= vld_p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_p1) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_sat;
         bu_ff   <= bu_in;
         bv_ff   <= q_v[BARY_W-1:0];
         bw_ff   <= q_w[BARY_W-1:0];
         pp_ff   <= pp_in;
         org_ff  <= in_side.ray_origin;
      end
      if (en_out) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign bary_total = (BARY_W+1)'(rsp_data_ff.bary_u) + (BARY_W+1)'(rsp_data_ff.bary_v)
                     + (BARY_W+1)'(rsp_data_ff.bary_w);

   `RTB_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.hit, rsp_data_ff == '0)
   `RTB_ASSERT_IMP(a_bary_sum, clock, reset, rsp_valid_ff && rsp_data_ff.hit, bary_total == (BARY_W+1)'(BARY_ONE))
   `RTB_ASSERT_IMP(a_stall_src, clock, reset, !in_ready, vld_p1_ff && rsp_valid_ff && !rsp_ready)
   `RTB_ASSERT_NXT(a_take_lands, clock, reset, in_valid && in_ready, vld_p1_ff)

endmodule
